@@ src/tt_pkg.sv @@
// shared types and constants for the transposition table engine
package tt_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int INDEX_W       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam bit TABLE_POW2    = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 8;
  localparam int SCORE_W = 16;
  localparam int BOUND_W = 2;
  localparam int MOVE_W  = 32;
  localparam int AGE_W   = 8;
  localparam int MODE_W  = 2;

  localparam int IN_FIELDS_W  = KEY_W + DEPTH_W + SCORE_W + SCORE_W + BOUND_W + MOVE_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SCORE_W + SCORE_W + MOVE_W + DEPTH_W + BOUND_W + AGE_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_USER_W   = 3;

  // key remainder for a table size that is not a power of two: byte residues are
  // weighted and summed below 2^FOLD_W, then reduced by a reciprocal multiply
  localparam int                FOLD_W     = 31;
  localparam int                FOLD_BYTES = KEY_W / 8;
  localparam logic [FOLD_W-1:0] FOLD_RECIP = FOLD_W'((64'd1 << FOLD_W) / 64'(TABLE_ENTRIES));

  // 2^(8*b) mod TABLE_ENTRIES, the weight of key byte b
  function automatic logic [INDEX_W-1:0] byte_weight(input int b);
    longint unsigned w;
    w = 64'd1;
    for (int i = 0; i < 8 * b; i++) begin
      w = w << 1;
      if (w >= 64'(TABLE_ENTRIES)) begin
        w = w - 64'(TABLE_ENTRIES);
      end
    end
    return INDEX_W'(w);
  endfunction

  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_STORE      = 2'd0,
    MODE_PROBE      = 2'd1,
    MODE_NEW_SEARCH = 2'd2,
    MODE_CLEAR      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OUT_REPLACE   = 2'd0,
    OUT_MOVE_ONLY = 2'd1,
    OUT_UNCHANGED = 2'd2,
    OUT_NOT_STORE = 2'd3
  } outcome_t;

  typedef struct packed {
    logic        [KEY_W-1:0]   key;
    logic signed [SCORE_W-1:0] score;
    logic signed [SCORE_W-1:0] eval;
    logic        [MOVE_W-1:0]  move;
    logic        [DEPTH_W-1:0] depth;
    logic        [BOUND_W-1:0] bound;
    logic        [AGE_W-1:0]   age;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    mode_t                     mode;
    logic        [KEY_W-1:0]   key;
    logic        [DEPTH_W-1:0] depth;
    logic signed [SCORE_W-1:0] score;
    logic signed [SCORE_W-1:0] eval;
    logic        [BOUND_W-1:0] bound;
    logic        [MOVE_W-1:0]  move;
  } req_t;

  typedef struct packed {
    logic     we;
    entry_t   wentry;
    outcome_t outcome;
  } update_t;

endpackage

@@ src/tt_ram.sv @@
// generic single-port ram with registered read
module tt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ src/tt_slot.sv @@
// entry index from the position key: key modulo the table size
module tt_slot (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tt_pkg::KEY_W-1:0]   key,
  output logic                       done,
  output logic [tt_pkg::INDEX_W-1:0] slot
);

  generate
    if (tt_pkg::TABLE_POW2) begin : g_mask
      assign done = start;
      assign slot = key[tt_pkg::INDEX_W-1:0];
    end else begin : g_fold
      // one key byte a cycle times its residue weight, then quotient estimate,
      // remainder, and a single correction step
      logic                          busy;
      logic                          fin;
      logic [3:0]                    cnt;
      logic [tt_pkg::KEY_W-1:0]      shreg;
      logic [tt_pkg::FOLD_W-1:0]     acc;
      logic [2*tt_pkg::FOLD_W-1:0]   prod;
      logic [tt_pkg::FOLD_W-1:0]     diff;
      logic [tt_pkg::INDEX_W-1:0]    rem;
      logic [tt_pkg::INDEX_W-1:0]    weight [tt_pkg::FOLD_BYTES];
      logic [tt_pkg::FOLD_W-1:0]     term;
      logic [tt_pkg::FOLD_W-1:0]     quot;

      for (genvar b = 0; b < tt_pkg::FOLD_BYTES; b++) begin : g_weight
        assign weight[b] = tt_pkg::byte_weight(b);
      end

      assign term = tt_pkg::FOLD_W'(shreg[7:0]) * tt_pkg::FOLD_W'(weight[cnt[2:0]]);
      assign quot = prod[2*tt_pkg::FOLD_W-1:tt_pkg::FOLD_W];

      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
          fin  <= 1'b0;
          cnt  <= '0;
        end else begin
          fin <= busy && (cnt == 4'd10);
          if (start && !busy) begin
            busy  <= 1'b1;
            cnt   <= '0;
            shreg <= key;
            acc   <= '0;
          end else if (busy) begin
            cnt <= cnt + 4'd1;
            if (cnt < 4'(tt_pkg::FOLD_BYTES)) begin
              acc   <= acc + term;
              shreg <= {8'd0, shreg[tt_pkg::KEY_W-1:8]};
            end else if (cnt == 4'd8) begin
              prod <= (2*tt_pkg::FOLD_W)'(acc) * (2*tt_pkg::FOLD_W)'(tt_pkg::FOLD_RECIP);
            end else if (cnt == 4'd9) begin
              diff <= acc - quot * tt_pkg::FOLD_W'(tt_pkg::TABLE_ENTRIES);
            end else begin
              // estimate is at most one short, so one subtract finishes it
              if (diff >= tt_pkg::FOLD_W'(tt_pkg::TABLE_ENTRIES)) begin
                rem <= tt_pkg::INDEX_W'(diff - tt_pkg::FOLD_W'(tt_pkg::TABLE_ENTRIES));
              end else begin
                rem <= tt_pkg::INDEX_W'(diff);
              end
              busy <= 1'b0;
            end
          end
        end
      end

      assign done = fin;
      assign slot = rem;
    end
  endgenerate

endmodule

@@ src/tt_update.sv @@
// replacement decision for a store against the entry read from the table
module tt_update (
  input  tt_pkg::entry_t                old,
  input  tt_pkg::req_t                  req,
  input  logic [tt_pkg::AGE_W-1:0]      generation,
  output tt_pkg::update_t               upd
);

  logic same;
  logic current;
  logic take;
  logic keep_deeper;

  always_comb begin
    same        = old.key == req.key;
    current     = old.age == generation;
    take        = (old.key == '0) || same || (req.depth >= old.depth) || !current;
    keep_deeper = same && current && (old.depth > req.depth) &&
                  (req.bound != tt_pkg::BOUND_EXACT);

    upd.we      = 1'b0;
    upd.wentry  = old;
    upd.outcome = tt_pkg::OUT_UNCHANGED;

    if (take) begin
      if (keep_deeper) begin
        // deeper entry of this search stays, only a given move is taken
        if (req.move != '0) begin
          upd.we          = 1'b1;
          upd.wentry.move = req.move;
          upd.outcome     = tt_pkg::OUT_MOVE_ONLY;
        end
      end else begin
        upd.we            = 1'b1;
        upd.wentry.key    = req.key;
        upd.wentry.score  = req.score;
        upd.wentry.eval   = req.eval;
        upd.wentry.move   = req.move;
        upd.wentry.depth  = req.depth;
        upd.wentry.bound  = req.bound;
        upd.wentry.age    = generation;
        upd.outcome       = tt_pkg::OUT_REPLACE;
      end
    end
  end

endmodule

@@ src/transposition_table_engine.sv @@
// Direct-mapped transposition table with depth/age replacement, one word in, one word out.
// A store or probe passes through these states before the next acceptance: ST_IDLE
// accepts it, ST_HASH forms the entry index and issues the read, ST_LOOKUP decides and writes
// back through the single port of the entry ram (a table size that is not a power of two
// stays in ST_HASH for the byte-folded key remainder). A new-search word is answered from
// ST_IDLE. A clear word, and reset, start a sweep that zeroes the table one entry a cycle,
// while no word is accepted; the result of a clear word is given at its end.
module transposition_table_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // key, search_depth, search_score, eval_value, bound_kind, move_code, zero pad
  input  logic [tt_pkg::IN_DATA_W-1:0]   s_tdata,
  // mode
  input  logic [tt_pkg::MODE_W-1:0]      s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // stored_score, stored_eval, stored_move, stored_depth, stored_bound, stored_age, zero pad
  output logic [tt_pkg::OUT_DATA_W-1:0]  m_tdata,
  // hit, store_outcome
  output logic [tt_pkg::OUT_USER_W-1:0]  m_tuser
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_HASH, ST_LOOKUP} state_t;

  state_t                     state;
  tt_pkg::req_t               req;
  tt_pkg::req_t               in_req;
  logic [tt_pkg::AGE_W-1:0]   generation;
  logic [tt_pkg::INDEX_W-1:0] clr_cnt;
  logic                       clr_report;
  logic                       clr_last;
  logic                       slot_start;
  logic                       slot_done;
  logic [tt_pkg::INDEX_W-1:0] slot;
  logic [tt_pkg::INDEX_W-1:0] slot_q;
  logic                       accept;
  logic                       res_load;

  logic [tt_pkg::INDEX_W-1:0] ram_addr;
  logic                       ram_we;
  tt_pkg::entry_t             ram_wdata;
  tt_pkg::entry_t             ram_rdata;
  tt_pkg::update_t            upd;
  logic                       probe_hit;

  // result register
  logic                       o_hit;
  tt_pkg::entry_t             o_entry;
  tt_pkg::outcome_t           o_outcome;

  assign in_req.mode  = tt_pkg::mode_t'(s_tuser);
  assign in_req.key   = s_tdata[63:0];
  assign in_req.depth = s_tdata[71:64];
  assign in_req.score = s_tdata[87:72];
  assign in_req.eval  = s_tdata[103:88];
  assign in_req.bound = s_tdata[105:104];
  assign in_req.move  = s_tdata[137:106];

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign clr_last = clr_cnt == tt_pkg::INDEX_W'(tt_pkg::TABLE_ENTRIES - 1);

  // a result word is loaded into the output register this cycle
  assign res_load = (state == ST_LOOKUP) ||
                    (accept && (in_req.mode == tt_pkg::MODE_NEW_SEARCH)) ||
                    ((state == ST_CLEAR) && clr_report && clr_last);

  tt_slot u_slot (
    .clk   (clk),
    .rst   (rst),
    .start (slot_start),
    .key   (req.key),
    .done  (slot_done),
    .slot  (slot)
  );

  tt_ram #(
    .WIDTH (tt_pkg::ENTRY_W),
    .DEPTH (tt_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  tt_update u_update (
    .old        (ram_rdata),
    .req        (req),
    .generation (generation),
    .upd        (upd)
  );

  assign probe_hit = ram_rdata.key == req.key;

  always_comb begin
    ram_addr  = slot;
    ram_we    = 1'b0;
    ram_wdata = upd.wentry;
    case (state)
      ST_CLEAR: begin
        ram_addr  = clr_cnt;
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      ST_LOOKUP: begin
        ram_addr = slot_q;
        ram_we   = (req.mode == tt_pkg::MODE_STORE) && upd.we;
      end
      default: begin
        ram_addr = slot;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      clr_report <= 1'b0;
      generation <= '0;
      slot_start <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      slot_start <= accept &&
                    (in_req.mode inside {tt_pkg::MODE_STORE, tt_pkg::MODE_PROBE});
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            req <= in_req;
            case (in_req.mode)
              tt_pkg::MODE_STORE, tt_pkg::MODE_PROBE: begin
                state <= ST_HASH;
              end
              tt_pkg::MODE_NEW_SEARCH: begin
                generation <= generation + 1'b1;
                o_hit      <= 1'b0;
                o_entry    <= '0;
                o_outcome  <= tt_pkg::OUT_NOT_STORE;
              end
              default: begin
                generation <= '0;
                clr_cnt    <= '0;
                clr_report <= 1'b1;
                state      <= ST_CLEAR;
              end
            endcase
          end
        end
        ST_HASH: begin
          if (slot_done) begin
            slot_q <= slot;
            state  <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (req.mode == tt_pkg::MODE_PROBE) begin
            o_hit     <= probe_hit;
            o_entry   <= probe_hit ? ram_rdata : '0;
            o_outcome <= tt_pkg::OUT_NOT_STORE;
          end else begin
            o_hit     <= 1'b0;
            o_entry   <= '0;
            o_outcome <= upd.outcome;
          end
          state <= ST_IDLE;
        end
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_last) begin
            state      <= ST_IDLE;
            clr_report <= 1'b0;
            if (clr_report) begin
              o_hit     <= 1'b0;
              o_entry   <= '0;
              o_outcome <= tt_pkg::OUT_NOT_STORE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {(tt_pkg::OUT_DATA_W - tt_pkg::OUT_FIELDS_W)'(0),
                    o_entry.age, o_entry.bound, o_entry.depth,
                    o_entry.move, o_entry.eval, o_entry.score};
  assign m_tuser = {o_outcome, o_hit};

endmodule
